FILE: rtl/core/srcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcf_pkg: shared definitions for the sensor reading change filter
// Field widths, configuration register codes and reset values, and the
// layout of one stored slot.
// ----------------------------------------------------------------------------
package srcf_pkg;

  localparam int ADDR_W     = 48;
  localparam int TIME_W     = 32;
  localparam int TEMP_W     = 15;
  localparam int HUM_W      = 7;
  localparam int BATT_W     = 8;
  localparam int SLOT_OUT_W = 6;

  localparam int SLOT_COUNT_DEF = 48;

  localparam int TEMP_DB_W  = 10;
  localparam int HUM_DB_W   = 7;
  localparam int BATT_DB_W  = 7;
  localparam int INTERVAL_W = 22;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 22;

  localparam logic [CFG_INDEX_W-1:0] CFG_TEMP_DB  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HUM_DB   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BATT_DB  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL = 3'd3;

  localparam logic [TEMP_DB_W-1:0]  TEMP_DB_RST  = 10'd10;
  localparam logic [HUM_DB_W-1:0]   HUM_DB_RST   = 7'd1;
  localparam logic [BATT_DB_W-1:0]  BATT_DB_RST  = 7'd1;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 22'd30000;

  typedef struct packed {
    logic [ADDR_W-1:0]        addr;
    logic [TIME_W-1:0]        last_time;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic signed [BATT_W-1:0] battery;
  } slot_entry_t;

endpackage

FILE: rtl/core/srcf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srcf_if: handshake channels of the sensor reading change filter
// One channel carries a decoded reading in, the other the filter decision out.
// ----------------------------------------------------------------------------
interface srcf_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [srcf_pkg::ADDR_W-1:0]          device_address;
  logic [srcf_pkg::TIME_W-1:0]          time_ms;
  logic signed [srcf_pkg::TEMP_W-1:0]   temperature;
  logic [srcf_pkg::HUM_W-1:0]           humidity;
  logic signed [srcf_pkg::BATT_W-1:0]   battery;

  modport source (output valid, device_address, time_ms, temperature, humidity, battery,
                  input ready);
  modport sink (input valid, device_address, time_ms, temperature, humidity, battery,
                output ready);
endinterface

interface srcf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            publish;
  logic [srcf_pkg::SLOT_OUT_W-1:0] slot_index;

  modport source (output valid, publish, slot_index, input ready);
  modport sink (input valid, publish, slot_index, output ready);
endinterface

FILE: rtl/core/sensor_reading_change_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_reading_change_filter: per-address deadband and dedup cache
// Looks a reading's address up in a slot memory, decides whether to forward it
// (new address, enough change or interval elapsed) and refreshes the slot if so.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  reading   in   valid/ready    device_address, time_ms, temperature,
//                                humidity, battery
//  result    out  valid/ready    publish, slot_index
//  cfg_*     in   cfg_write      cfg_index, cfg_data
//
// A reading's slot scan stops early when its address hits; the scan reads the
// memory one entry per cycle. Reset is synchronous and empties every slot at
// once; no clearing pass is needed. A result waits in the output register
// while the next reading is scanned; only the final decision step waits for it.
// ----------------------------------------------------------------------------
module sensor_reading_change_filter #(
  parameter int SLOT_COUNT = srcf_pkg::SLOT_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [srcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [srcf_pkg::CFG_DATA_W-1:0]    cfg_data,
  srcf_in_if.sink                            reading,
  srcf_out_if.source                         result
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FETCH  = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);

  // Configuration registers.
  logic [srcf_pkg::TEMP_DB_W-1:0]  temp_db;
  logic [srcf_pkg::HUM_DB_W-1:0]   hum_db;
  logic [srcf_pkg::BATT_DB_W-1:0]  batt_db;
  logic [srcf_pkg::INTERVAL_W-1:0] interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_db  <= srcf_pkg::TEMP_DB_RST;
      hum_db   <= srcf_pkg::HUM_DB_RST;
      batt_db  <= srcf_pkg::BATT_DB_RST;
      interval <= srcf_pkg::INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        srcf_pkg::CFG_TEMP_DB:  temp_db  <= cfg_data[srcf_pkg::TEMP_DB_W-1:0];
        srcf_pkg::CFG_HUM_DB:   hum_db   <= cfg_data[srcf_pkg::HUM_DB_W-1:0];
        srcf_pkg::CFG_BATT_DB:  batt_db  <= cfg_data[srcf_pkg::BATT_DB_W-1:0];
        srcf_pkg::CFG_INTERVAL: interval <= cfg_data[srcf_pkg::INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state.
  logic [1:0]       state;
  logic [CNT_W-1:0] rd_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             hit;
  logic [IDX_W-1:0] slot;
  logic             out_valid;
  logic [SLOT_COUNT-1:0] in_use;

  // Reading under work.
  logic [srcf_pkg::ADDR_W-1:0]        cur_addr;
  logic [srcf_pkg::TIME_W-1:0]        cur_time;
  logic signed [srcf_pkg::TEMP_W-1:0] cur_temp;
  logic [srcf_pkg::HUM_W-1:0]         cur_hum;
  logic signed [srcf_pkg::BATT_W-1:0] cur_batt;

  // Result register.
  logic                            out_publish;
  logic [srcf_pkg::SLOT_OUT_W-1:0] out_slot;

  // Slot memory.
  srcf_pkg::slot_entry_t mem [SLOT_COUNT];
  srcf_pkg::slot_entry_t rdata;
  srcf_pkg::slot_entry_t wdata;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;

  logic accept_in;
  logic out_free;
  logic issue;
  logic cmp_used;
  logic cmp_match;
  logic decide_go;

  logic signed [srcf_pkg::TEMP_W:0] temp_diff;
  logic [srcf_pkg::TEMP_W:0]        temp_abs;
  logic signed [srcf_pkg::HUM_W:0]  hum_diff;
  logic [srcf_pkg::HUM_W:0]         hum_abs;
  logic signed [srcf_pkg::BATT_W:0] batt_diff;
  logic [srcf_pkg::BATT_W:0]        batt_abs;
  logic [srcf_pkg::TIME_W-1:0]      elapsed;
  logic                             changed;
  logic                             publish_now;

  assign accept_in = reading.valid && reading.ready;
  assign out_free  = !out_valid || result.ready;
  assign issue     = (state == ST_SCAN) && (rd_cnt < CNT_END);
  assign cmp_used  = in_use[cmp_idx];
  assign cmp_match = cmp_vld && cmp_used && (rdata.addr == cur_addr);
  assign decide_go = (state == ST_DECIDE) && out_free;

  assign reading.ready = (state == ST_IDLE);
  assign result.valid      = out_valid;
  assign result.publish    = out_publish;
  assign result.slot_index = out_slot;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_cnt[IDX_W-1:0];
    if (issue) begin
      rd_en = 1'b1;
    end else if (state == ST_FETCH) begin
      rd_en   = 1'b1;
      rd_addr = slot;
    end
  end

  // Deadband tests against the fetched slot.
  always_comb begin
    temp_diff = {cur_temp[srcf_pkg::TEMP_W-1], cur_temp}
              - {rdata.temperature[srcf_pkg::TEMP_W-1], rdata.temperature};
    temp_abs  = temp_diff[srcf_pkg::TEMP_W] ? -temp_diff : temp_diff;
    hum_diff  = {1'b0, cur_hum} - {1'b0, rdata.humidity};
    hum_abs   = hum_diff[srcf_pkg::HUM_W] ? -hum_diff : hum_diff;
    batt_diff = {cur_batt[srcf_pkg::BATT_W-1], cur_batt}
              - {rdata.battery[srcf_pkg::BATT_W-1], rdata.battery};
    batt_abs  = batt_diff[srcf_pkg::BATT_W] ? -batt_diff : batt_diff;
    elapsed   = cur_time - rdata.last_time;
    changed   = (temp_abs > (srcf_pkg::TEMP_W + 1)'(temp_db))
             || (hum_abs >= (srcf_pkg::HUM_W + 1)'(hum_db))
             || (!cur_batt[srcf_pkg::BATT_W-1]
                 && (batt_abs >= (srcf_pkg::BATT_W + 1)'(batt_db)));
    publish_now = !hit || changed
               || (elapsed >= srcf_pkg::TIME_W'(interval));
  end

  assign mem_we = decide_go && publish_now;
  assign wdata  = '{addr: cur_addr, last_time: cur_time, temperature: cur_temp,
                    humidity: cur_hum, battery: cur_batt};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      cur_addr <= reading.device_address;
      cur_time <= reading.time_ms;
      cur_temp <= reading.temperature;
      cur_hum  <= reading.humidity;
      cur_batt <= reading.battery;
    end
    if (decide_go) begin
      out_publish <= publish_now;
      out_slot    <= srcf_pkg::SLOT_OUT_W'(slot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_cnt     <= '0;
      cmp_vld    <= 1'b0;
      cmp_idx    <= '0;
      free_found <= 1'b0;
      free_idx   <= '0;
      hit        <= 1'b0;
      slot       <= '0;
      out_valid  <= 1'b0;
      in_use     <= '0;
    end else begin
      if (decide_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept_in) begin
            state      <= ST_SCAN;
            rd_cnt     <= '0;
            cmp_vld    <= 1'b0;
            free_found <= 1'b0;
            hit        <= 1'b0;
          end
        end
        ST_SCAN: begin
          // Reads run one entry ahead of the compare.
          cmp_vld <= issue;
          cmp_idx <= rd_cnt[IDX_W-1:0];
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (cmp_match) begin
            hit   <= 1'b1;
            slot  <= cmp_idx;
            state <= ST_FETCH;
          end else if (cmp_vld) begin
            if (!cmp_used && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (cmp_idx == LAST_IDX) begin
              // No hit: lowest free slot, or slot 0 when the table is full.
              if (free_found) begin
                slot <= free_idx;
              end else if (!cmp_used) begin
                slot <= cmp_idx;
              end else begin
                slot <= '0;
              end
              state <= ST_DECIDE;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            if (publish_now) begin
              in_use[slot] <= 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
